// ----- rtl/spa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and sizes for the sparse polynomial adder.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_TERMS  = 32;
  localparam int COEF_BITS  = 16;
  localparam int EXPON_W    = 16;
  localparam int SUM_W      = COEF_BITS + 1;
  localparam int OUT_COEF_W = 17;
  localparam int IDX_W      = $clog2(MAX_TERMS);
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);

  // request opcodes carried in s_tuser
  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;

  // bit positions in m_tuser
  localparam int UB_TERM_VALID = 0;
  localparam int UB_OVERFLOW   = 1;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef;
    logic        [EXPON_W-1:0]   expon;
  } term_t;

  typedef struct packed {
    logic                    take_a;
    logic                    take_b;
    logic                    emit;
    logic signed [SUM_W-1:0] coef;
    logic [EXPON_W-1:0]      expon;
  } merge_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

endpackage : spa_pkg
`default_nettype wire

// ----- rtl/spa_term_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spa_term_mem
// Term list storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spa_term_mem (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [spa_pkg::IDX_W-1:0] waddr,
  input  spa_pkg::term_t                 wdata,
  input  wire logic [spa_pkg::IDX_W-1:0] raddr,
  output spa_pkg::term_t                 rdata
);
  import spa_pkg::*;

  term_t mem [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : spa_term_mem
`default_nettype wire

// ----- rtl/spa_merge_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spa_merge_unit
// One merge step: compares the head terms of both lists, adds on a tie.
// ----------------------------------------------------------------------------
module spa_merge_unit (
  input  spa_pkg::term_t     head_a,
  input  spa_pkg::term_t     head_b,
  input  wire logic          have_a,
  input  wire logic          have_b,
  output spa_pkg::merge_res_t res
);
  import spa_pkg::*;

  logic signed [SUM_W-1:0] ext_a;
  logic signed [SUM_W-1:0] ext_b;
  logic signed [SUM_W-1:0] sum;

  assign ext_a = SUM_W'(head_a.coef);
  assign ext_b = SUM_W'(head_b.coef);
  assign sum   = ext_a + ext_b;

  always_comb begin
    res = '0;
    if (have_a && have_b && (head_a.expon == head_b.expon)) begin
      res.take_a = 1'b1;
      res.take_b = 1'b1;
      res.emit   = (sum != '0);  // cancelled terms vanish
      res.coef   = sum;
      res.expon  = head_a.expon;
    end else if (!have_b || (have_a && (head_a.expon > head_b.expon))) begin
      res.take_a = have_a;
      res.emit   = have_a;
      res.coef   = ext_a;
      res.expon  = head_a.expon;
    end else begin
      res.take_b = 1'b1;
      res.emit   = 1'b1;
      res.coef   = ext_b;
      res.expon  = head_b.expon;
    end
  end

endmodule : spa_merge_unit
`default_nettype wire

// ----- rtl/sparse_poly_add_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_poly_add_merge
// Sparse polynomial adder: loads two term lists, merges them on request.
// ----------------------------------------------------------------------------
// Input stream: s_tuser selects the request (load A, load B, compute);
// a load carries one term in s_tdata. Loads are taken back to back while
// idle; a term sent to a full list is dropped and sets the sticky overflow
// flag. A compute request starts the merge sequencer, which steps the
// shared compare/add unit once per cycle, unless the output stalls it,
// over the two term memories, one head term per list per step; s_tready
// is low for the whole merge. Results leave through an output register,
// one term per transfer on the master side, held in a lookahead register
// so the final term can carry tlast. An empty sum gives one item with
// term_valid low. Compute clears both lists and the flag.
// When the receiver stalls the sequencer waits; nothing is lost.
// Reset clears the counts, the flag and the handshake state; list
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sparse_poly_add_merge (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // term_coef[15:0], term_expon[31:16]
  input  wire logic [1:0]  s_tuser,  // func[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // out_coef[16:0], out_expon[32:17], zero pad
  output logic             m_tlast,  // last_term
  output logic [1:0]       m_tuser   // term_valid[0], overflow_seen[1]
);
  import spa_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] count_a, count_b;
  logic [CNT_W-1:0] ia, ia_next;
  logic [CNT_W-1:0] ib, ib_next;
  logic             overflow_flag;
  logic             ovf_cap;

  logic                    hold_valid;
  logic signed [SUM_W-1:0] hold_coef;
  logic [EXPON_W-1:0]      hold_expon;

  logic signed [SUM_W-1:0] out_coef;
  logic [EXPON_W-1:0]      out_expon;
  logic                    term_valid;
  logic                    last_term;
  logic                    overflow_seen;

  logic  accept;
  logic  [1:0] func;
  term_t in_term;
  logic  we_a, we_b;
  term_t head_a, head_b;
  logic  have_a, have_b;
  logic  out_free;
  merge_res_t res;

  logic advance, load_hold, push_out, finish;

  assign func          = s_tuser;
  assign in_term.coef  = s_tdata[COEF_BITS-1:0];
  assign in_term.expon = s_tdata[16 +: EXPON_W];
  assign accept        = s_tvalid && s_tready;

  assign we_a = accept && (func == FUNC_LOAD_A) && (count_a < CNT_W'(MAX_TERMS));
  assign we_b = accept && (func == FUNC_LOAD_B) && (count_b < CNT_W'(MAX_TERMS));

  assign have_a   = ia < count_a;
  assign have_b   = ib < count_b;
  assign out_free = !m_tvalid || m_tready;

  // read address follows the next head index so data lines up with ia/ib
  spa_term_mem u_mem_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[IDX_W-1:0]),
    .wdata (in_term),
    .raddr (ia_next[IDX_W-1:0]),
    .rdata (head_a)
  );

  spa_term_mem u_mem_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[IDX_W-1:0]),
    .wdata (in_term),
    .raddr (ib_next[IDX_W-1:0]),
    .rdata (head_b)
  );

  spa_merge_unit u_unit (
    .head_a (head_a),
    .head_b (head_b),
    .have_a (have_a),
    .have_b (have_b),
    .res    (res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (func == FUNC_COMPUTE)) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    advance   = 1'b0;
    load_hold = 1'b0;
    push_out  = 1'b0;
    finish    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_MERGE: begin
        if (!have_a && !have_b) begin
          finish   = out_free;
          push_out = out_free;
        end else if (!res.emit) begin
          advance = 1'b1;
        end else if (!hold_valid) begin
          advance   = 1'b1;
          load_hold = 1'b1;
        end else if (out_free) begin
          advance   = 1'b1;
          load_hold = 1'b1;
          push_out  = 1'b1;
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    ia_next = ia;
    ib_next = ib;
    if (finish) begin
      ia_next = '0;
      ib_next = '0;
    end else if (advance) begin
      if (res.take_a) ia_next = ia + CNT_W'(1);
      if (res.take_b) ib_next = ib + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      ia            <= '0;
      ib            <= '0;
      overflow_flag <= 1'b0;
      ovf_cap       <= 1'b0;
      hold_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      ia    <= ia_next;
      ib    <= ib_next;
      if (we_a) count_a <= count_a + CNT_W'(1);
      if (we_b) count_b <= count_b + CNT_W'(1);
      if (accept && (func == FUNC_LOAD_A) && !we_a) overflow_flag <= 1'b1;
      if (accept && (func == FUNC_LOAD_B) && !we_b) overflow_flag <= 1'b1;
      if (accept && (func == FUNC_COMPUTE)) ovf_cap <= overflow_flag;
      if (finish) begin
        count_a       <= '0;
        count_b       <= '0;
        overflow_flag <= 1'b0;
      end
      if (load_hold) begin
        hold_valid <= 1'b1;
      end else if (finish) begin
        hold_valid <= 1'b0;
      end
      if (push_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_hold) begin
      hold_coef  <= res.coef;
      hold_expon <= res.expon;
    end
    if (push_out) begin
      overflow_seen <= ovf_cap;
      last_term     <= finish;
      if (hold_valid) begin
        out_coef   <= hold_coef;
        out_expon  <= hold_expon;
        term_valid <= 1'b1;
      end else begin
        // empty sum
        out_coef   <= '0;
        out_expon  <= '0;
        term_valid <= 1'b0;
      end
    end
  end

  assign m_tdata = {7'd0, out_expon, OUT_COEF_W'($unsigned(out_coef))};
  assign m_tlast = last_term;
  always_comb begin
    m_tuser                = '0;
    m_tuser[UB_TERM_VALID] = term_valid;
    m_tuser[UB_OVERFLOW]   = overflow_seen;
  end

`ifndef NO_ASSERTIONS
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("lookahead term left over outside a merge");

  a_ia_bound: assert property (@(posedge clk) disable iff (rst)
    (ia <= count_a) && (ib <= count_b))
    else $error("merge index ran past its list");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[UB_TERM_VALID]) |-> m_tlast)
    else $error("empty-sum item not marked last");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    finish |=> (count_a == '0) && (count_b == '0) && !overflow_flag)
    else $error("lists not cleared after compute");
`endif

endmodule : sparse_poly_add_merge
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse polynomial adder. Streams load and
// compute requests, predicts the merged term list of every compute and checks
// each output term in order, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spa_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 180;
  localparam int HOLD_CYCLES     = 250;
  localparam int DRAIN_CYCLES    = 2 * MAX_TERMS + 16;

  typedef struct packed {
    logic signed [OUT_COEF_W-1:0] coef;
    logic [EXPON_W-1:0]           expon;
    logic                         valid;
    logic                         last;
    logic                         ovf;
  } sum_term_t;

  // Keeps its own copy of both term lists and the drop flag; a compute
  // request turns them into the queue of terms the block must emit.
  class poly_sum_board;
    term_t     list_a[MAX_TERMS];
    term_t     list_b[MAX_TERMS];
    int        n_a = 0;
    int        n_b = 0;
    bit        dropped_any = 1'b0;
    sum_term_t sums_due[$];
    int        errors = 0;
    int        terms_checked = 0;
    int        empty_sums = 0;
    int        merges = 0;
    int        dropped_loads = 0;

    function sum_term_t sum_term(logic signed [OUT_COEF_W-1:0] coef,
                                 logic [EXPON_W-1:0] expon, logic valid);
      sum_term_t st;
      st.coef  = coef;
      st.expon = expon;
      st.valid = valid;
      st.last  = 1'b0;
      st.ovf   = dropped_any;
      return st;
    endfunction

    function void note_request(logic [1:0] func, term_t t);
      sum_term_t                    run[$];
      logic signed [OUT_COEF_W-1:0] s;
      int                           ia;
      int                           ib;
      case (func)
        FUNC_LOAD_A: begin
          if (n_a < MAX_TERMS) begin
            list_a[n_a] = t;
            n_a++;
          end else begin
            dropped_any = 1'b1;
            dropped_loads++;
          end
        end
        FUNC_LOAD_B: begin
          if (n_b < MAX_TERMS) begin
            list_b[n_b] = t;
            n_b++;
          end else begin
            dropped_any = 1'b1;
            dropped_loads++;
          end
        end
        FUNC_COMPUTE: begin
          ia = 0;
          ib = 0;
          while (ia < n_a || ib < n_b) begin
            if (ia < n_a && ib < n_b && list_a[ia].expon == list_b[ib].expon) begin
              s = $signed(list_a[ia].coef) + $signed(list_b[ib].coef);
              if (s != 0) run.push_back(sum_term(s, list_a[ia].expon, 1'b1));
              ia++;
              ib++;
            end else if (ib >= n_b || (ia < n_a && list_a[ia].expon > list_b[ib].expon)) begin
              run.push_back(sum_term($signed(list_a[ia].coef), list_a[ia].expon, 1'b1));
              ia++;
            end else begin
              run.push_back(sum_term($signed(list_b[ib].coef), list_b[ib].expon, 1'b1));
              ib++;
            end
          end
          if (run.size() == 0) begin
            run.push_back(sum_term('0, '0, 1'b0));
            empty_sums++;
          end
          run[run.size()-1].last = 1'b1;
          foreach (run[i]) sums_due.push_back(run[i]);
          merges++;
          n_a = 0;
          n_b = 0;
          dropped_any = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void fail_note(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_term(logic [39:0] data, logic last, logic [1:0] user);
      sum_term_t got;
      sum_term_t want;
      got.coef  = data[OUT_COEF_W-1:0];
      got.expon = data[OUT_COEF_W +: EXPON_W];
      got.valid = user[UB_TERM_VALID];
      got.last  = last;
      got.ovf   = user[UB_OVERFLOW];
      terms_checked++;
      if (sums_due.size() == 0) begin
        fail_note($sformatf({"term with nothing pending: coef %0d expon %0d",
                             " valid %0b last %0b ovf %0b"},
                            got.coef, got.expon, got.valid, got.last, got.ovf));
        return;
      end
      want = sums_due.pop_front();
      if (got.coef !== want.coef || got.expon !== want.expon || got.valid !== want.valid ||
          got.last !== want.last || got.ovf !== want.ovf) begin
        fail_note($sformatf({"term %0d: expected coef %0d expon %0d valid %0b last %0b ovf %0b,",
                             " got coef %0d expon %0d valid %0b last %0b ovf %0b"},
                            terms_checked, want.coef, want.expon, want.valid, want.last,
                            want.ovf, got.coef, got.expon, got.valid, got.last, got.ovf));
      end
    endfunction

    function int pending();
      return sums_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = FUNC_LOAD_A;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  poly_sum_board board;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int requests_sent = 0;
  int hold_reqs = 0;
  int hold_taken = 0;
  int hold_left = 0;

  sparse_poly_add_merge dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_reqs != hold_taken) begin
      hold_taken <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_term(m_tdata, m_tlast, m_tuser);
  end

  function automatic term_t mk_term(logic [15:0] coef, logic [15:0] expon);
    term_t t;
    t.coef  = coef;
    t.expon = expon;
    return t;
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(15))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // s_tvalid stays high after acceptance; the caller's next request or idle
  // cycle replaces or lowers it
  task automatic send_request(input logic [1:0] func, input term_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t.expon, t.coef};
    s_tuser  <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(func, t);
    if (func != FUNC_UNUSED) requests_sent++;
  endtask

  // Loads size_a/size_b terms (sizes over MAX_TERMS overfill a list) with
  // descending exponents unless mixed, some shared by A and B; computes if finish.
  task automatic merge_case(input int size_a, input int size_b, input bit mixed,
                            input bit finish);
    int unsigned pool[$];
    bit          taken[int unsigned];
    int unsigned v;
    int          span;
    int          rem_a;
    int          rem_b;
    int          pick;
    term_t       a_terms[$];
    term_t       b_terms[$];
    term_t       t;
    term_t       u;
    span = (size_a + size_b <= 40 && $urandom_range(3) == 0) ? 63 : 65535;
    while (pool.size() < size_a + size_b) begin
      v = $urandom_range(span);
      if (!taken.exists(v)) begin
        taken[v] = 1'b1;
        pool.push_back(v);
      end
    end
    pool.rsort();
    rem_a = size_a;
    rem_b = size_b;
    foreach (pool[i]) begin
      t = mk_term(rand_coef(), 16'(pool[i]));
      pick = $urandom_range(2);
      if (rem_a > 0 && rem_b > 0 && pick == 0) begin
        // shared exponent; often the negated coefficient so the sum cancels
        u = mk_term(($urandom_range(2) == 0) ? -t.coef : rand_coef(), t.expon);
        a_terms.push_back(t);
        b_terms.push_back(u);
        rem_a--;
        rem_b--;
      end else if (rem_a > 0 && (rem_b == 0 || pick == 1)) begin
        a_terms.push_back(t);
        rem_a--;
      end else if (rem_b > 0) begin
        b_terms.push_back(t);
        rem_b--;
      end
    end
    if (mixed) begin
      a_terms.shuffle();
      b_terms.shuffle();
    end
    while (a_terms.size() + b_terms.size() > 0) begin
      if ($urandom_range(11) == 0)
        send_request(FUNC_UNUSED, mk_term(16'($urandom), 16'($urandom)));
      if (b_terms.size() == 0 || (a_terms.size() > 0 && $urandom_range(1) == 0))
        send_request(FUNC_LOAD_A, a_terms.pop_front());
      else
        send_request(FUNC_LOAD_B, b_terms.pop_front());
    end
    if (finish) send_request(FUNC_COMPUTE, mk_term(16'($urandom), 16'($urandom)));
  endtask

  task automatic random_case();
    int r;
    int sa;
    int sb;
    r = $urandom_range(99);
    if (r < 8) begin
      sa = MAX_TERMS + $urandom_range(1, 4);
      sb = $urandom_range(8);
      if ($urandom_range(1) == 1) begin
        r  = sa;
        sa = sb;
        sb = r;
      end
    end else if (r < 20) begin
      sa = $urandom_range(10, MAX_TERMS);
      sb = $urandom_range(10, MAX_TERMS);
    end else begin
      sa = $urandom_range(6);
      sb = $urandom_range(6);
    end
    merge_case(sa, sb, $urandom_range(9) == 0, $urandom_range(9) != 0);
  endtask

  initial begin
    int target;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored code, empty sum, widest sums, cancel, copies, order
    send_request(FUNC_UNUSED, mk_term(16'h1234, 16'hbeef));
    send_request(FUNC_COMPUTE, mk_term(16'h0000, 16'h0000));
    send_request(FUNC_LOAD_A, mk_term(16'h7fff, 16'hffff));
    send_request(FUNC_LOAD_B, mk_term(16'h7fff, 16'hffff));
    send_request(FUNC_LOAD_A, mk_term(16'h8000, 16'd40000));
    send_request(FUNC_LOAD_B, mk_term(16'h8000, 16'd40000));
    send_request(FUNC_LOAD_A, mk_term(16'd100, 16'd300));
    send_request(FUNC_LOAD_B, mk_term(-16'sd100, 16'd300));
    send_request(FUNC_LOAD_B, mk_term(16'd5, 16'd200));
    send_request(FUNC_UNUSED, mk_term(16'hffff, 16'hffff));
    send_request(FUNC_LOAD_A, mk_term(-16'sd7, 16'd100));
    send_request(FUNC_LOAD_A, mk_term(16'd12, 16'd0));
    send_request(FUNC_LOAD_B, mk_term(-16'sd3, 16'd0));
    send_request(FUNC_COMPUTE, mk_term(16'hffff, 16'hffff));
    // every term cancels: empty sum
    send_request(FUNC_LOAD_A, mk_term(16'd5, 16'd10));
    send_request(FUNC_LOAD_B, mk_term(-16'sd5, 16'd10));
    send_request(FUNC_COMPUTE, mk_term(16'h0000, 16'h0000));
    // unsorted list and a zero coefficient that is copied, not dropped
    send_request(FUNC_LOAD_A, mk_term(16'd1, 16'd5));
    send_request(FUNC_LOAD_A, mk_term(16'd2, 16'd50));
    send_request(FUNC_LOAD_B, mk_term(16'd3, 16'd20));
    send_request(FUNC_LOAD_B, mk_term(16'd0, 16'd7));
    send_request(FUNC_COMPUTE, mk_term(16'h0000, 16'h0000));

    for (int ph = 0; ph < 4; ph++) begin
      s_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clk);
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 48;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 48;
        end
        default: begin
          tx_idle_pct  = 33;
          rx_stall_pct = 33;
        end
      endcase
      target = requests_sent + RANDOM_REQUESTS / 4;
      if (ph == 2) begin
        // sink holds off while the source keeps pushing: overfilled list,
        // a long merge and more requests behind it
        hold_reqs++;
        merge_case(MAX_TERMS + 2, 20, 1'b0, 1'b1);
        merge_case(4, 3, 1'b0, 1'b1);
      end
      while (requests_sent < target) random_case();
    end
    send_request(FUNC_COMPUTE, mk_term(16'h0000, 16'h0000));
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d merges, %0d empty sums,",
             requests_sent, board.merges, board.empty_sums);
    $display("%0d loads dropped on full lists, %0d result terms checked, %0d failures",
             board.dropped_loads, board.terms_checked, board.errors);
    if (board.errors == 0) begin
      $display("sparse_poly_add_merge: match");
    end else begin
      $display("sparse_poly_add_merge: mismatch");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("timeout: %0d terms still pending", board.pending());
    $display("sparse_poly_add_merge: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/spa_pkg.sv
rtl/spa_term_mem.sv
rtl/spa_merge_unit.sv
rtl/sparse_poly_add_merge.sv
tb/sv/tb.sv
